[src/wake_frame_receiver_defines.svh]
// Assertion macros for the deframer back end.
`ifndef WAKE_FRAME_RECEIVER_DEFINES_SVH
`define WAKE_FRAME_RECEIVER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define WFR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define WFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/wfr_pkg.sv]
`default_nettype none

package wfr_pkg;

    localparam int CFG_INDEX_W         = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] CRC_POLY            = 8'h31;
    localparam logic [7:0] FRAME_START_RESET   = 8'hC0;
    localparam logic [7:0] ESCAPE_RESET        = 8'hDB;
    localparam logic [7:0] ESC_START_RESET     = 8'hDC;
    localparam logic [7:0] ESC_ESCAPE_RESET    = 8'hDD;
    localparam logic [7:0] CRC_SEED_RESET      = 8'hFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_START = 3'd0,
        REG_ESCAPE      = 3'd1,
        REG_ESC_START   = 3'd2,
        REG_ESC_ESCAPE  = 3'd3,
        REG_CRC_SEED    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] frame_start;
        logic [7:0] escape;
        logic [7:0] esc_start;
        logic [7:0] esc_escape;
        logic [7:0] crc_seed;
    } cfg_t;

    // Classified line events handed from the front to the back.
    typedef enum logic [1:0] {
        TOK_START  = 2'd0,
        TOK_BYTE   = 2'd1,
        TOK_BADESC = 2'd2
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
    } tok_t;

    typedef enum logic [2:0] {
        KIND_ADDR   = 3'd0,
        KIND_CMD    = 3'd1,
        KIND_LEN    = 3'd2,
        KIND_DATA   = 3'd3,
        KIND_STATUS = 3'd4
    } byte_kind_t;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_BAD = 2'd1,
        ST_ABORT   = 2'd2,
        ST_BAD_ESC = 2'd3
    } frame_status_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRC  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]    data;
        byte_kind_t    kind;
        frame_status_t status;
        logic          end_flag;
    } result_t;

    // One CRC-8 byte step, MSB first, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[src/wfr_front.sv]
`default_nettype none

module wfr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire wfr_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    rx_byte,
    output logic               push_valid,
    input  wire logic          push_ready,
    output wfr_pkg::tok_t      push_data
);
    import wfr_pkg::*;

    logic pending_reg;
    logic pending_next;
    logic accept;
    logic keep;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    // Frame start wins, then a pending escape, then a fresh escape.
    always_comb
    begin
        keep           = 1'b1;
        pending_next   = pending_reg;
        push_data.kind = TOK_BYTE;
        push_data.data = rx_byte;
        if (rx_byte == cfg.frame_start)
        begin
            push_data.kind = TOK_START;
            pending_next   = 1'b0;
        end
        else if (pending_reg)
        begin
            pending_next = 1'b0;
            if (rx_byte == cfg.esc_start)
            begin
                push_data.data = cfg.frame_start;
            end
            else if (rx_byte == cfg.esc_escape)
            begin
                push_data.data = cfg.escape;
            end
            else
            begin
                push_data.kind = TOK_BADESC;
                push_data.data = 8'd0;
            end
        end
        else if (rx_byte == cfg.escape)
        begin
            // Drop the escape itself; the next byte completes the pair.
            keep         = 1'b0;
            pending_next = 1'b1;
        end
    end

    assign push_valid = in_valid && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

[src/wfr_queue.sv]
`default_nettype none

module wfr_queue #(
    parameter int DEPTH = wfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire wfr_pkg::tok_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output wfr_pkg::tok_t      pop_data
);
    import wfr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[src/wfr_back.sv]
`default_nettype none
`include "wake_frame_receiver_defines.svh"

module wfr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire wfr_pkg::cfg_t cfg,
    input  wire logic          tok_valid,
    output logic               tok_ready,
    input  wire wfr_pkg::tok_t tok,
    output logic               res_valid,
    input  wire logic          res_ready,
    output wfr_pkg::result_t   res
);
    import wfr_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [8:0] seen_reg;
    logic [8:0] seen_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res_next;
    logic       emit;
    logic       advance;
    logic [8:0] seen_inc;
    logic       data_done;

    assign tok_ready = !out_valid_reg || res_ready;
    assign advance   = tok_valid && tok_ready;
    assign seen_inc  = seen_reg + 9'd1;
    assign data_done = (seen_inc >= ({1'b0, len_reg} + 9'd4));

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == PH_HUNT)
        begin
            if (tok.kind == TOK_START)
            begin
                phase_next = PH_ADDR;
            end
        end
        else if (tok.kind != TOK_BYTE)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                PH_ADDR: phase_next = PH_CMD;
                PH_CMD:  phase_next = PH_LEN;
                PH_LEN:  phase_next = (tok.data == 8'd0) ? PH_CRC : PH_DATA;
                PH_DATA: phase_next = data_done ? PH_CRC : PH_DATA;
                PH_CRC:  phase_next = PH_HUNT;
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // Result and frame counters.
    always_comb
    begin
        emit              = 1'b0;
        res_next.data     = tok.data;
        res_next.kind     = KIND_DATA;
        res_next.status   = ST_GOOD;
        res_next.end_flag = 1'b0;
        seen_next         = seen_reg;
        len_next          = len_reg;
        crc_next          = crc_reg;
        if (phase_reg == PH_HUNT)
        begin
            if (tok.kind == TOK_START)
            begin
                seen_next = 9'd1;
                len_next  = 8'd0;
                crc_next  = crc8_step(cfg.crc_seed, tok.data);
            end
        end
        else
        begin
            unique case (tok.kind)
                TOK_START, TOK_BADESC:
                begin
                    emit              = 1'b1;
                    res_next.data     = 8'd0;
                    res_next.kind     = KIND_STATUS;
                    res_next.status   = (tok.kind == TOK_START) ? ST_ABORT : ST_BAD_ESC;
                    res_next.end_flag = 1'b1;
                end
                TOK_BYTE:
                begin
                    emit = 1'b1;
                    if (phase_reg == PH_CRC)
                    begin
                        res_next.kind     = KIND_STATUS;
                        res_next.status   = (tok.data == crc_reg) ? ST_GOOD : ST_CRC_BAD;
                        res_next.end_flag = 1'b1;
                    end
                    else
                    begin
                        crc_next  = crc8_step(crc_reg, tok.data);
                        seen_next = seen_inc;
                        unique case (phase_reg)
                            PH_ADDR: res_next.kind = KIND_ADDR;
                            PH_CMD:  res_next.kind = KIND_CMD;
                            PH_LEN:
                            begin
                                res_next.kind = KIND_LEN;
                                len_next      = tok.data;
                            end
                            default: res_next.kind = KIND_DATA;
                        endcase
                    end
                end
                default: emit = 1'b0;
            endcase
            if (res_next.end_flag)
            begin
                seen_next = 9'd0;
                len_next  = 8'd0;
                crc_next  = cfg.crc_seed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            seen_reg      <= 9'd0;
            len_reg       <= 8'd0;
            crc_reg       <= CRC_SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `WFR_ASSERT(a_hunt_silent, clk, rst_n, !(advance && (phase_reg == PH_HUNT) && emit),
        "result emitted while hunting")
    `WFR_ASSERT(a_end_is_status, clk, rst_n,
        !out_valid_reg || (out_reg.end_flag == (out_reg.kind == KIND_STATUS)),
        "frame end flag disagrees with status kind")
    `WFR_ASSERT_NEXT(a_close_hunts, clk, rst_n, advance && emit && res_next.end_flag,
        (phase_reg == PH_HUNT) && (seen_reg == 9'd0), "frame close did not return to hunt")

endmodule

`default_nettype wire

[src/wake_frame_receiver.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------
// input    | in        | in_valid / in_ready  | rx_byte
// output   | out       | out_valid / out_ready| out_byte, byte_kind, frame_status,
//          |           |                      | frame_end
// config   | in        | cfg_write            | cfg_index, cfg_data
//
// Sustained rate is one request per cycle unless the output stalls; the front classifies
// a request into the queue, then the back takes one CRC step into the output register.
// Reset is asynchronous and active low; it loads the code registers with their defaults
// and leaves the block hunting, with no clearing pass. A stalled output holds the back,
// the queue absorbs up to QUEUE_DEPTH requests, then in_ready drops.
`default_nettype none

module wake_frame_receiver #(
    parameter int QUEUE_DEPTH = wfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [wfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [7:0]                           out_byte,
    output logic [2:0]                           byte_kind,
    output logic [1:0]                           frame_status,
    output logic                                 frame_end
);
    import wfr_pkg::*;

    cfg_t    cfg_reg;
    logic    q_push_valid;
    logic    q_push_ready;
    tok_t    q_push_data;
    logic    q_pop_valid;
    logic    q_pop_ready;
    tok_t    q_pop_data;
    result_t res;

    // Code registers; the user must write them only while the block is idle, which the
    // block does not enforce, and unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_start <= FRAME_START_RESET;
            cfg_reg.escape      <= ESCAPE_RESET;
            cfg_reg.esc_start   <= ESC_START_RESET;
            cfg_reg.esc_escape  <= ESC_ESCAPE_RESET;
            cfg_reg.crc_seed    <= CRC_SEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_START: cfg_reg.frame_start <= cfg_data;
                REG_ESCAPE:      cfg_reg.escape      <= cfg_data;
                REG_ESC_START:   cfg_reg.esc_start   <= cfg_data;
                REG_ESC_ESCAPE:  cfg_reg.esc_escape  <= cfg_data;
                REG_CRC_SEED:    cfg_reg.crc_seed    <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Front: detect frame start, undo escape stuffing, drop escape bytes.
    wfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    // Queue between classification and framing, so each side stalls on its own.
    wfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // Back: frame phases, length tracking, CRC check and the output register.
    wfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_valid (q_pop_valid),
        .tok_ready (q_pop_ready),
        .tok       (q_pop_data),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign out_byte     = res.data;
    assign byte_kind    = res.kind;
    assign frame_status = res.status;
    assign frame_end    = res.end_flag;

endmodule

`default_nettype wire
